@@ sv/rmmmv_pkg.sv @@
// rmmmv_pkg: shared constants and types for the running statistics block
// no dependencies

package rmmmv_pkg;

  localparam int LANES       = 4;
  localparam int LANE_BITS   = 2;
  localparam int COUNT_BITS  = 32;
  localparam int VAR_BITS    = 48;
  localparam int MUL_A_BITS  = 49;
  localparam int MUL_B_BITS  = 32;
  localparam int DIV_N_BITS  = 82;
  localparam int DIV_D_BITS  = 32;
  localparam int SQ_LO       = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_MUL,
    ST_MEAN_DIV,
    ST_SQ_OLD,
    ST_SQ_NEW,
    ST_VAR_MUL,
    ST_VAR_DIV,
    ST_OUT
  } state_e;

endpackage

@@ sv/running_min_max_mean_variance.sv @@
// running_min_max_mean_variance: per-lane running min, max, mean and variance
// depends on rmmmv_pkg, rmmmv_mul and rmmmv_div
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o | x, y, z, yaw samples
//   out     | output    | out_valid_o/out_ready_i | lane, min, max, mean, variance, count, last
//
// each lane runs through one serial multiplier and one serial divider in turn:
// mean product, mean quotient, two difference squares, variance product and
// variance quotient, for the four lanes of a request one after another.
// the divider, at one quotient bit per cycle over 82 bits, is the slowest unit.
// reset clears count, means and variances at once; no clearing pass.
// a result waits in the output register while the next lane is computed;
// a stalled output holds the sequencer only when the next lane result is ready.

module running_min_max_mean_variance #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]           x_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]           y_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]           z_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]           yaw_sample_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [rmmmv_pkg::LANE_BITS-1:0]         lane_o,
  output logic signed [SAMPLE_BITS-1:0]           minimum_o,
  output logic signed [SAMPLE_BITS-1:0]           maximum_o,
  output logic signed [SAMPLE_BITS-1:0]           mean_o,
  output logic [rmmmv_pkg::VAR_BITS-1:0]          variance_o,
  output logic [rmmmv_pkg::COUNT_BITS-1:0]        sample_count_o,
  output logic                                    last_o
);

  localparam int SW  = SAMPLE_BITS;
  localparam int PW  = SW + 33;
  localparam int AW  = rmmmv_pkg::MUL_A_BITS;
  localparam int BW  = rmmmv_pkg::MUL_B_BITS;
  localparam int NW  = rmmmv_pkg::DIV_N_BITS;
  localparam int VW  = rmmmv_pkg::VAR_BITS;
  localparam int CB  = rmmmv_pkg::COUNT_BITS;
  localparam int LB  = rmmmv_pkg::LANE_BITS;
  localparam int NL  = rmmmv_pkg::LANES;
  localparam int SQ_LO_C = rmmmv_pkg::SQ_LO;

  rmmmv_pkg::state_e state_q, state_d;

  logic signed [SW-1:0] smp_q  [NL];
  logic signed [SW-1:0] min_q  [NL];
  logic signed [SW-1:0] max_q  [NL];
  logic signed [SW-1:0] mean_q [NL];
  logic [VW-1:0]        var_q  [NL];
  logic [CB-1:0]        count_q, count_d;
  logic [CB-1:0]        m_q;
  logic                 first_q;
  logic [LB-1:0]        lane_q;
  logic                 launched_q, launched_d;

  logic signed [PW-1:0] s_q;
  logic signed [SW-1:0] nm_q;
  logic [AW-1:0]        a_q;
  logic [VW-1:0]        b_q;
  logic [NW-1:0]        vnum_q;

  logic                 out_valid_q;
  logic [LB-1:0]        out_lane_q;
  logic signed [SW-1:0] out_min_q, out_max_q, out_mean_q;
  logic [VW-1:0]        out_var_q;
  logic [CB-1:0]        out_count_q;
  logic                 out_last_q;

  logic                 in_acc, out_load, last_lane;
  logic                 mul_start, mul_done, div_start, div_done;
  logic [AW-1:0]        mul_a;
  logic [BW-1:0]        mul_b;
  logic [AW+BW-1:0]     mul_p;
  logic [NW-1:0]        div_num, div_q;

  logic signed [SW-1:0] cur_x, old_mean;
  logic [SW-1:0]        old_mag;
  logic signed [PW-1:0] prod_s, s_new;
  logic [PW-1:0]        s_abs;
  logic [SW-1:0]        q_mean;
  logic signed [SW:0]   d_old, d_new;
  logic [SW:0]          dm_old, dm_new;
  logic [AW-1:0]        dw_old, dw_new;
  logic [BW-1:0]        sat_old, sat_new;
  logic [VW-1:0]        var_new;

  assign in_acc    = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == rmmmv_pkg::ST_IDLE);
  assign out_load  = (state_q == rmmmv_pkg::ST_OUT) && (!out_valid_q || out_ready_i);
  assign last_lane = (lane_q == LB'(NL - 1));

  assign cur_x    = smp_q[lane_q];
  assign old_mean = mean_q[lane_q];
  assign old_mag  = old_mean[SW-1] ? SW'(-old_mean) : SW'(old_mean);

  assign prod_s = $signed({1'b0, mul_p[SW+31:0]});
  assign s_new  = (old_mean[SW-1] ? -prod_s : prod_s) + PW'(cur_x);
  assign s_abs  = s_q[PW-1] ? PW'(-s_q) : PW'(s_q);
  assign q_mean = div_q[SW-1:0];

  // difference magnitudes, held at 32 bits before squaring
  assign d_old  = {nm_q[SW-1], nm_q} - {old_mean[SW-1], old_mean};
  assign d_new  = {nm_q[SW-1], nm_q} - {cur_x[SW-1], cur_x};
  assign dm_old = d_old[SW] ? (SW+1)'(-d_old) : (SW+1)'(d_old);
  assign dm_new = d_new[SW] ? (SW+1)'(-d_new) : (SW+1)'(d_new);
  assign dw_old = AW'(dm_old);
  assign dw_new = AW'(dm_new);
  assign sat_old = (|dw_old[AW-1:BW]) ? '1 : dw_old[BW-1:0];
  assign sat_new = (|dw_new[AW-1:BW]) ? '1 : dw_new[BW-1:0];

  assign var_new = (|div_q[NW-1:VW]) ? '1 : div_q[VW-1:0];

  assign count_d = (count_q != '1) ? count_q + 1'b1 : count_q;

  rmmmv_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  rmmmv_div #(.NW(NW), .DW(CB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (count_q),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmmmv_pkg::ST_IDLE:     if (in_acc) state_d = rmmmv_pkg::ST_MEAN_MUL;
      rmmmv_pkg::ST_MEAN_MUL: if (mul_done) state_d = rmmmv_pkg::ST_MEAN_DIV;
      rmmmv_pkg::ST_MEAN_DIV: if (div_done) state_d = rmmmv_pkg::ST_SQ_OLD;
      rmmmv_pkg::ST_SQ_OLD:   if (mul_done) state_d = rmmmv_pkg::ST_SQ_NEW;
      rmmmv_pkg::ST_SQ_NEW:   if (mul_done) state_d = rmmmv_pkg::ST_VAR_MUL;
      rmmmv_pkg::ST_VAR_MUL:  if (mul_done) state_d = rmmmv_pkg::ST_VAR_DIV;
      rmmmv_pkg::ST_VAR_DIV:  if (div_done) state_d = rmmmv_pkg::ST_OUT;
      rmmmv_pkg::ST_OUT: begin
        if (out_load) state_d = last_lane ? rmmmv_pkg::ST_IDLE : rmmmv_pkg::ST_MEAN_MUL;
      end
      default: state_d = rmmmv_pkg::ST_IDLE;
    endcase
  end

  // unit launches and operand selection
  always_comb begin
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_num   = '0;
    unique case (state_q)
      rmmmv_pkg::ST_MEAN_MUL: begin
        mul_start = !launched_q;
        mul_a     = AW'(old_mag);
        mul_b     = m_q;
      end
      rmmmv_pkg::ST_MEAN_DIV: begin
        div_start = !launched_q;
        div_num   = NW'(s_abs);
      end
      rmmmv_pkg::ST_SQ_OLD: begin
        mul_start = !launched_q;
        mul_a     = AW'(sat_old);
        mul_b     = sat_old;
      end
      rmmmv_pkg::ST_SQ_NEW: begin
        mul_start = !launched_q;
        mul_a     = AW'(sat_new);
        mul_b     = sat_new;
      end
      rmmmv_pkg::ST_VAR_MUL: begin
        mul_start = !launched_q;
        mul_a     = a_q;
        mul_b     = m_q;
      end
      rmmmv_pkg::ST_VAR_DIV: begin
        div_start = !launched_q;
        div_num   = vnum_q;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    launched_d = launched_q;
    if (mul_start || div_start) launched_d = 1'b1;
    if (mul_done || div_done)   launched_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmmmv_pkg::ST_IDLE;
      launched_q  <= 1'b0;
      count_q     <= '0;
      lane_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NL; i++) begin
        min_q[i]  <= '0;
        max_q[i]  <= '0;
        mean_q[i] <= '0;
        var_q[i]  <= '0;
      end
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      if (in_acc) begin
        count_q <= count_d;
        lane_q  <= '0;
      end
      if (state_q == rmmmv_pkg::ST_VAR_DIV && div_done) begin
        if (first_q || cur_x < min_q[lane_q]) min_q[lane_q] <= cur_x;
        if (first_q || cur_x > max_q[lane_q]) max_q[lane_q] <= cur_x;
        mean_q[lane_q] <= nm_q;
        var_q[lane_q]  <= var_new;
      end
      if (out_load) begin
        lane_q <= last_lane ? '0 : lane_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q[0] <= x_sample_i;
      smp_q[1] <= y_sample_i;
      smp_q[2] <= z_sample_i;
      smp_q[3] <= yaw_sample_i;
      first_q  <= (count_q == '0);
      m_q      <= count_d - 1'b1;
    end
    if (state_q == rmmmv_pkg::ST_MEAN_MUL && mul_done) s_q <= s_new;
    if (state_q == rmmmv_pkg::ST_MEAN_DIV && div_done) begin
      nm_q <= s_q[PW-1] ? SW'(-q_mean) : SW'(q_mean);
    end
    if (state_q == rmmmv_pkg::ST_SQ_OLD && mul_done) begin
      a_q <= {1'b0, var_q[lane_q]} + {1'b0, mul_p[VW+SQ_LO_C-1:SQ_LO_C]};
    end
    if (state_q == rmmmv_pkg::ST_SQ_NEW && mul_done) b_q <= mul_p[VW+SQ_LO_C-1:SQ_LO_C];
    if (state_q == rmmmv_pkg::ST_VAR_MUL && mul_done) begin
      vnum_q <= {1'b0, mul_p} + NW'(b_q);
    end
    if (out_load) begin
      out_lane_q  <= lane_q;
      out_min_q   <= min_q[lane_q];
      out_max_q   <= max_q[lane_q];
      out_mean_q  <= mean_q[lane_q];
      out_var_q   <= var_q[lane_q];
      out_count_q <= count_q;
      out_last_q  <= last_lane;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lane_o         = out_lane_q;
  assign minimum_o      = out_min_q;
  assign maximum_o      = out_max_q;
  assign mean_o         = out_mean_q;
  assign variance_o     = out_var_q;
  assign sample_count_o = out_count_q;
  assign last_o         = out_last_q;

endmodule

@@ sv/rmmmv_mul.sv @@
// rmmmv_mul: shift-add multiplier, one multiplier bit per cycle
// depends on nothing but its parameters

module rmmmv_mul #(
  parameter int AW = 49,
  parameter int BW = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] p_o
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_q;
  logic [AW-1:0] acc_q, acc_d;
  logic [BW-1:0] b_q, b_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [AW:0]   sum;

  assign sum   = {1'b0, acc_q} + (b_q[0] ? {1'b0, a_q} : '0);
  assign acc_d = sum[AW:1];
  assign b_d   = {sum[0], b_q[BW-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= b_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = {acc_q, b_q};

endmodule

@@ sv/rmmmv_div.sv @@
// rmmmv_div: restoring divider, one quotient bit per cycle
// depends on nothing but its parameters; the divisor must be non-zero

module rmmmv_div #(
  parameter int NW = 82,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          qbit;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = (trial >= {1'b0, den_q});
  assign rem_d = qbit ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], qbit};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

@@ sv/rmmmv_checker.sv @@
// rmmmv_checker: port-level checks on the running statistics block, bound to the top
// depends on rmmmv_pkg and running_min_max_mean_variance

module rmmmv_checker #(
  parameter int SAMPLE_BITS = 32
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic signed [SAMPLE_BITS-1:0]      x_sample_i,
  input logic signed [SAMPLE_BITS-1:0]      y_sample_i,
  input logic signed [SAMPLE_BITS-1:0]      z_sample_i,
  input logic signed [SAMPLE_BITS-1:0]      yaw_sample_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [rmmmv_pkg::LANE_BITS-1:0]    lane_o,
  input logic signed [SAMPLE_BITS-1:0]      minimum_o,
  input logic signed [SAMPLE_BITS-1:0]      maximum_o,
  input logic signed [SAMPLE_BITS-1:0]      mean_o,
  input logic [rmmmv_pkg::VAR_BITS-1:0]     variance_o,
  input logic [rmmmv_pkg::COUNT_BITS-1:0]   sample_count_o,
  input logic                               last_o
);

  localparam logic [rmmmv_pkg::LANE_BITS-1:0] LastLane =
    rmmmv_pkg::LANE_BITS'(rmmmv_pkg::LANES - 1);

  // last marks exactly the final lane
  a_last_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (lane_o == LastLane)))
    else $error("last flag does not match lane");

  // mean stays inside the observed range
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (minimum_o <= mean_o) && (mean_o <= maximum_o))
    else $error("mean outside min/max");

  // a result only follows at least one request
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_count_o != '0))
    else $error("result with zero count");

  // in_ready falls in the cycle after a request is accepted
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready straight after a request");

endmodule

bind running_min_max_mean_variance rmmmv_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_rmmmv_chk (.*);
